FILE: hdl/ptts_pkg.sv
// package: shared types and constants for the periodic task timer scheduler
package ptts_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int TIME_WIDTH_DEF = 32;

  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_ADD = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_DISPATCH = 3'd3;
  localparam logic [2:0] OP_SET_TIME = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] task_id;
    logic [15:0] start_delay;
    logic [15:0] period_ticks;
    logic [31:0] time_value;
  } in_item_t;

  typedef struct packed {
    logic ok;
    logic [7:0] ready_id;
    logic [31:0] now_time;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input item, clear scan index
    logic step;      // process slot at scan index, advance
    logic finish;    // apply end-of-operation update and form result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done; // scan index has passed the last relevant slot
  } dp_stat_t;

endpackage

FILE: hdl/periodic_task_timer_scheduler_top.sv
// top level: periodic task timer scheduler
//
//  channel | signals                        | payload
//  in      | in_valid, in_stall (out)       | in_item  (ptts_pkg::in_item_t)
//  out     | out_valid, out_stall (in)      | out_item (ptts_pkg::out_item_t)
//
// one item at a time: a load, then one slot walked per step over the occupied
// slots (up to NUM_SLOTS), a step to end the walk, a finish step, then the
// result offered until out_stall is low. the slot walk sets the total time
// per item, which output stalls lengthen further.
// reset clears slot count, ready flags and clock; slot contents need none.
// in_stall stays high from acceptance until the result is taken.
module periodic_task_timer_scheduler_top #(
  parameter int NUM_SLOTS = ptts_pkg::NUM_SLOTS_DEF,
  parameter int COUNT_WIDTH = ptts_pkg::COUNT_WIDTH_DEF,
  parameter int TIME_WIDTH = ptts_pkg::TIME_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ptts_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ptts_pkg::out_item_t  out_item
);

  ptts_pkg::dp_cmd_t  cmd;
  ptts_pkg::dp_stat_t stat;

  ptts_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .stat(stat)
  );

  ptts_dp #(
    .NUM_SLOTS(NUM_SLOTS), .COUNT_WIDTH(COUNT_WIDTH), .TIME_WIDTH(TIME_WIDTH)
  ) u_dp (
    .clk(clk), .rst(rst), .in_item(in_item), .cmd(cmd), .stat(stat),
    .out_item(out_item)
  );

endmodule

FILE: hdl/ptts_ctrl.sv
// controller: sequences load, slot walk and result hand-off
module ptts_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output ptts_pkg::dp_cmd_t   cmd,
  input  ptts_pkg::dp_stat_t  stat
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN, S_OUT} state_t;
  state_t state;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.load = (state == S_IDLE) && in_valid;
    cmd.step = (state == S_SCAN) && !stat.scan_done;
    cmd.finish = (state == S_FIN);
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_SCAN;
        S_SCAN: if (stat.scan_done) state <= S_FIN;
        S_FIN: begin
          state <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: if (!out_stall) begin
          state <= S_IDLE;
          out_valid <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/ptts_dp.sv
// datapath: slot table, clock and one-slot-per-cycle walk
module ptts_dp #(
  parameter int NUM_SLOTS = ptts_pkg::NUM_SLOTS_DEF,
  parameter int COUNT_WIDTH = ptts_pkg::COUNT_WIDTH_DEF,
  parameter int TIME_WIDTH = ptts_pkg::TIME_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ptts_pkg::in_item_t   in_item,
  input  ptts_pkg::dp_cmd_t    cmd,
  output ptts_pkg::dp_stat_t   stat,
  output ptts_pkg::out_item_t  out_item
);

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);

  logic [7:0]             slot_ids [NUM_SLOTS];
  logic [COUNT_WIDTH-1:0] countdowns [NUM_SLOTS];
  logic [COUNT_WIDTH-1:0] periods [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]   ready_flags;
  logic [CW-1:0]          slot_count;
  logic [TIME_WIDTH-1:0]  system_clock;

  ptts_pkg::in_item_t cur;
  logic [CW-1:0] idx;       // walk position
  logic          found;     // id match or ready slot found
  logic [IW-1:0] hit_pos;
  logic          shifting;  // compaction in progress
  logic [7:0]    rid;

  logic [IW-1:0] ip;
  logic [COUNT_WIDTH-1:0] cd, cd_rl;
  logic [CW-1:0] idx_p1;

  assign ip = idx[IW-1:0];
  assign idx_p1 = idx + CW'(1);
  assign cd = countdowns[ip];
  assign cd_rl = ((cd == '0) && (periods[ip] != '0)) ? periods[ip] : cd;

  // walk ends at slot_count, early for add once found, and at once for set-time and undefined ops
  always_comb begin
    stat.scan_done = (idx >= slot_count)
      || (found && !shifting && (cur.op == ptts_pkg::OP_ADD))
      || (cur.op == ptts_pkg::OP_SET_TIME)
      || (cur.op > ptts_pkg::OP_SET_TIME);
  end

  // table walk and end-of-operation updates
  always_ff @(posedge clk) begin
    if (rst) begin
      ready_flags <= '0;
      slot_count <= '0;
      system_clock <= '0;
      found <= 1'b0;
      shifting <= 1'b0;
      idx <= '0;
    end else if (cmd.load) begin
      cur <= in_item;
      idx <= '0;
      found <= 1'b0;
      shifting <= 1'b0;
      rid <= '0;
    end else if (cmd.step) begin
      idx <= idx_p1;
      unique case (cur.op)
        ptts_pkg::OP_TICK: begin
          if (cd == '0) ready_flags[ip] <= 1'b1;
          countdowns[ip] <= cd_rl - COUNT_WIDTH'(1);
        end
        ptts_pkg::OP_ADD: begin
          if (slot_ids[ip] == cur.task_id) found <= 1'b1;
        end
        ptts_pkg::OP_REMOVE, ptts_pkg::OP_DISPATCH: begin
          if (shifting) begin
            // move this slot down one place
            slot_ids[hit_pos] <= slot_ids[ip];
            countdowns[hit_pos] <= countdowns[ip];
            periods[hit_pos] <= periods[ip];
            ready_flags[hit_pos] <= ready_flags[ip];
            hit_pos <= ip;
          end else if (!found) begin
            if ((cur.op == ptts_pkg::OP_REMOVE) ? (slot_ids[ip] == cur.task_id)
                                                : ready_flags[ip]) begin
              found <= 1'b1;
              hit_pos <= ip;
              rid <= slot_ids[ip];
              if (cur.op == ptts_pkg::OP_REMOVE || periods[ip] == '0)
                shifting <= 1'b1;
              else
                ready_flags[ip] <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end else if (cmd.finish) begin
      unique case (cur.op)
        ptts_pkg::OP_TICK: system_clock <= system_clock + TIME_WIDTH'(1);
        ptts_pkg::OP_ADD: begin
          if (!found && (slot_count < CW'(NUM_SLOTS))) begin
            slot_ids[slot_count[IW-1:0]] <= cur.task_id;
            countdowns[slot_count[IW-1:0]] <= COUNT_WIDTH'(cur.start_delay);
            periods[slot_count[IW-1:0]] <= COUNT_WIDTH'(cur.period_ticks);
            ready_flags[slot_count[IW-1:0]] <= 1'b0;
            slot_count <= slot_count + CW'(1);
          end else begin
            // full table rejects the add like a duplicate id
            found <= 1'b1;
          end
        end
        ptts_pkg::OP_REMOVE, ptts_pkg::OP_DISPATCH: begin
          if (shifting) slot_count <= slot_count - CW'(1);
        end
        ptts_pkg::OP_SET_TIME: system_clock <= TIME_WIDTH'(cur.time_value);
        default: ;
      endcase
    end
  end

  // result formed from state after finish
  always_comb begin
    out_item.ok = 1'b0;
    out_item.ready_id = '0;
    unique case (cur.op)
      ptts_pkg::OP_ADD: out_item.ok = !found;
      ptts_pkg::OP_REMOVE: out_item.ok = found;
      ptts_pkg::OP_DISPATCH: begin
        out_item.ok = found;
        out_item.ready_id = rid;
      end
      default: ;
    endcase
    out_item.now_time = 32'(system_clock);
  end

endmodule
